[hw/rtl/rotation_matrix_to_quaternion_top_macros.svh]
// Assertion macros shared by the rotation matrix to quaternion RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RMQ_ASSERT(lbl, prop, msg)
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/rmq_pkg.sv]
// Shared constants, stage types and arithmetic step functions for the
// rotation matrix to quaternion pipeline. Depends on nothing.
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int SUM_W     = 19;              // trace and s before clamping
  localparam int S_W       = 17;              // positive s, at most 114687
  localparam int NUM_W     = 17;              // signed numerators
  localparam int MAG_W     = 17;              // numerator magnitude
  localparam int RAD_W     = 32;              // s scaled, padded to even width
  localparam int ROOT_W    = RAD_W / 2;
  localparam int SQR_W     = ROOT_W + 3;      // square root partial remainder
  localparam int DVD_W     = 32;
  localparam int DVS_W     = ROOT_W + 1;
  localparam int REM_W     = DVS_W + 1;
  localparam int LANES     = 4;               // w, x, y, z
  localparam int STEPS     = 2;               // digit steps per stage
  localparam int SQ_STAGES = ROOT_W / STEPS;
  localparam int DV_STAGES = DVD_W / STEPS;

  localparam logic signed [SUM_W-1:0] ONE_FX = SUM_W'(1 << FRAC_BITS);
  localparam logic [DVD_W-1:0] POS_LIMIT = DVD_W'(32767);
  localparam logic [DVD_W-1:0] NEG_LIMIT = DVD_W'(32768);
  localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

  // Numerators per lane after the front stage.
  typedef struct packed {
    logic                        degen;
    logic [LANES-1:0]            half_sel;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } rmq_num_t;

  typedef struct packed {
    logic             degen;
    logic [LANES-1:0] half_sel;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] nz;
  } rmq_meta_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SQR_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } rmq_sq_t;

  typedef struct packed {
    logic [DVD_W-1:0] dvd;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] quo;
  } rmq_lane_t;

  typedef struct packed {
    rmq_meta_t                  meta;
    logic [ROOT_W-1:0]          root;
    logic [DVS_W-1:0]           dvs;
    logic [LANES-1:0][$bits(rmq_lane_t)-1:0] lane;
  } rmq_dstage_t;

  function automatic logic signed [NUM_W-1:0] fx_add(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b);
    return NUM_W'(a) + NUM_W'(b);
  endfunction

  function automatic logic signed [NUM_W-1:0] fx_sub(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b);
    return NUM_W'(a) - NUM_W'(b);
  endfunction

  // Magnitude of a signed numerator; the most negative value maps to 65536.
  function automatic logic [MAG_W-1:0] fx_mag(logic signed [NUM_W-1:0] n);
    return n[NUM_W-1] ? MAG_W'(~n + NUM_W'(1)) : MAG_W'(n);
  endfunction

  // One digit of the integer square root, two radicand bits at a time.
  function automatic rmq_sq_t sqrt_step(rmq_sq_t cur);
    rmq_sq_t          res;
    logic [SQR_W-1:0] rem2;
    logic [SQR_W-1:0] trial;
    rem2  = {cur.rem[SQR_W-3:0], cur.rad[RAD_W-1:RAD_W-2]};
    trial = SQR_W'({cur.root, 2'b01});
    res.rad = {cur.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      res.rem  = rem2 - trial;
      res.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = rem2;
      res.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // One bit of restoring division.
  function automatic rmq_lane_t div_step(rmq_lane_t cur, logic [DVS_W-1:0] dvs);
    rmq_lane_t        res;
    logic [REM_W-1:0] rem2;
    rem2    = {cur.rem[REM_W-2:0], cur.dvd[DVD_W-1]};
    res.dvd = {cur.dvd[DVD_W-2:0], 1'b0};
    if (rem2 >= REM_W'(dvs)) begin
      res.rem = rem2 - REM_W'(dvs);
      res.quo = {cur.quo[DVD_W-2:0], 1'b1};
    end else begin
      res.rem = rem2;
      res.quo = {cur.quo[DVD_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // Apply the numerator sign and saturate to the output range.
  function automatic logic signed [DATA_W-1:0] sat_div(logic [DVD_W-1:0] quo, logic neg);
    if (!neg) begin
      return (quo > POS_LIMIT) ? OUT_MAX : $signed(quo[DATA_W-1:0]);
    end
    return (quo >= NEG_LIMIT) ? OUT_MIN : $signed(-quo[DATA_W-1:0]);
  endfunction

endpackage

[hw/rtl/rmq_front.sv]
// Front stage: trace, branch and pivot choice, square root argument and the
// signed numerators of the divided terms. Depends on rmq_pkg.
module rmq_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [15:0]            r00,
  input  logic signed [15:0]            r01,
  input  logic signed [15:0]            r02,
  input  logic signed [15:0]            r10,
  input  logic signed [15:0]            r11,
  input  logic signed [15:0]            r12,
  input  logic signed [15:0]            r20,
  input  logic signed [15:0]            r21,
  input  logic signed [15:0]            r22,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [rmq_pkg::S_W-1:0]       dn_s,
  output rmq_pkg::rmq_num_t             dn_num
);
  import rmq_pkg::*;

  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;

  logic                     v_r;
  logic [S_W-1:0]           s_r;
  rmq_num_t                 num_r;
  logic                     en;
  logic signed [SUM_W-1:0]  trace;
  logic signed [SUM_W-1:0]  s_val;
  logic [1:0]               idx;
  logic                     trace_pos;
  logic                     degen;
  logic [LANES-1:0]         half_sel;
  logic signed [NUM_W-1:0]  num [LANES];
  logic [S_W-1:0]           s_nxt;
  rmq_num_t                 num_nxt;

  // Branch choice and per-lane numerators.
  always_comb begin
    trace     = SUM_W'(r00) + SUM_W'(r11) + SUM_W'(r22);
    trace_pos = trace > 0;
    idx = IDX_X;
    if (r11 > r00) idx = IDX_Y;
    if (r22 > ((idx == IDX_Y) ? r11 : r00)) idx = IDX_Z;
    for (int l = 0; l < LANES; l++) num[l] = '0;
    if (trace_pos) begin
      half_sel = 4'b0001;
      s_val    = trace + ONE_FX;
      num[1]   = fx_sub(r21, r12);
      num[2]   = fx_sub(r02, r20);
      num[3]   = fx_sub(r10, r01);
    end else begin
      case (idx)
        IDX_X: begin
          half_sel = 4'b0010;
          s_val    = SUM_W'(r00) - SUM_W'(r11) - SUM_W'(r22) + ONE_FX;
          num[0]   = fx_sub(r21, r12);
          num[2]   = fx_add(r10, r01);
          num[3]   = fx_add(r20, r02);
        end
        IDX_Y: begin
          half_sel = 4'b0100;
          s_val    = SUM_W'(r11) - SUM_W'(r22) - SUM_W'(r00) + ONE_FX;
          num[0]   = fx_sub(r02, r20);
          num[1]   = fx_add(r01, r10);
          num[3]   = fx_add(r21, r12);
        end
        default: begin
          half_sel = 4'b1000;
          s_val    = SUM_W'(r22) - SUM_W'(r00) - SUM_W'(r11) + ONE_FX;
          num[0]   = fx_sub(r10, r01);
          num[1]   = fx_add(r02, r20);
          num[2]   = fx_add(r12, r21);
        end
      endcase
    end
    degen = !trace_pos && (s_val <= 0);
    s_nxt = degen ? '0 : s_val[S_W-1:0];
    num_nxt.degen    = degen;
    num_nxt.half_sel = half_sel;
    for (int l = 0; l < LANES; l++) begin
      num_nxt.neg[l] = num[l][NUM_W-1];
      num_nxt.mag[l] = fx_mag(num[l]);
    end
  end

  assign en       = !v_r || dn_ready;
  assign up_ready = en;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= s_nxt;
      num_r <= num_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_s     = s_r;
  assign dn_num   = num_r;

endmodule

[hw/rtl/rmq_sqrt.sv]
// Pipelined integer square root of s scaled by the fraction bits, two
// result bits per stage; numerators ride along. Depends on rmq_pkg.
module rmq_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [rmq_pkg::S_W-1:0]       up_s,
  input  rmq_pkg::rmq_num_t             up_num,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output logic [rmq_pkg::ROOT_W-1:0]    dn_root,
  output rmq_pkg::rmq_num_t             dn_num
);
  import rmq_pkg::*;

  logic [SQ_STAGES-1:0] v_r;
  logic [SQ_STAGES-1:0] en;
  rmq_sq_t              st_r  [SQ_STAGES];
  rmq_num_t             num_r [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    logic     v_in;
    rmq_sq_t  st_in;
    rmq_sq_t  st_nxt;
    rmq_num_t num_in;

    // Stage input: the radicand enters at the first stage.
    if (g == 0) begin : g_first
      assign v_in   = up_valid;
      assign st_in  = '{rad: RAD_W'({up_s, {FRAC_BITS{1'b0}}}), rem: '0, root: '0};
      assign num_in = up_num;
    end else begin : g_next
      assign v_in   = v_r[g-1];
      assign st_in  = st_r[g-1];
      assign num_in = num_r[g-1];
    end

    // Enable: a stage moves when empty or when the one after it moves.
    if (g == SQ_STAGES - 1) begin : g_last_en
      assign en[g] = !v_r[g] || dn_ready;
    end else begin : g_mid_en
      assign en[g] = !v_r[g] || en[g+1];
    end

    always_comb begin
      st_nxt = st_in;
      for (int k = 0; k < STEPS; k++) st_nxt = sqrt_step(st_nxt);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en[g]) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        st_r[g]  <= st_nxt;
        num_r[g] <= num_in;
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[SQ_STAGES-1];
  assign dn_root  = st_r[SQ_STAGES-1].root;
  assign dn_num   = num_r[SQ_STAGES-1];

endmodule

[hw/rtl/rmq_div.sv]
// Four-lane pipelined restoring divider: each lane forms
// (|n| * 2^FRAC_BITS + root) / (2 * root), two bits per stage. Depends on rmq_pkg.
module rmq_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [rmq_pkg::ROOT_W-1:0]    up_root,
  input  rmq_pkg::rmq_num_t             up_num,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output rmq_pkg::rmq_dstage_t          dn_data
);
  import rmq_pkg::*;

  logic [DV_STAGES-1:0] v_r;
  logic [DV_STAGES-1:0] en;
  rmq_dstage_t          st_r [DV_STAGES];
  rmq_dstage_t          first_in;

  // Dividends, divisor and metadata for a new beat.
  always_comb begin
    first_in.meta.degen    = up_num.degen;
    first_in.meta.half_sel = up_num.half_sel;
    first_in.meta.neg      = up_num.neg;
    first_in.root          = up_root;
    first_in.dvs           = {up_root, 1'b0};
    for (int l = 0; l < LANES; l++) begin
      first_in.meta.nz[l] = |up_num.mag[l];
      first_in.lane[l] = rmq_lane_t'{
        dvd: DVD_W'({up_num.mag[l], {FRAC_BITS{1'b0}}}) + DVD_W'(up_root),
        rem: '0,
        quo: '0
      };
    end
  end

  for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
    logic        v_in;
    rmq_dstage_t st_in;
    rmq_dstage_t st_nxt;

    if (g == 0) begin : g_first
      assign v_in  = up_valid;
      assign st_in = first_in;
    end else begin : g_next
      assign v_in  = v_r[g-1];
      assign st_in = st_r[g-1];
    end

    if (g == DV_STAGES - 1) begin : g_last_en
      assign en[g] = !v_r[g] || dn_ready;
    end else begin : g_mid_en
      assign en[g] = !v_r[g] || en[g+1];
    end

    // Two quotient bits for every lane.
    always_comb begin
      st_nxt = st_in;
      for (int l = 0; l < LANES; l++) begin
        for (int k = 0; k < STEPS; k++) begin
          st_nxt.lane[l] = div_step(rmq_lane_t'(st_nxt.lane[l]), st_in.dvs);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en[g]) begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        st_r[g] <= st_nxt;
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v_r[DV_STAGES-1];
  assign dn_data  = st_r[DV_STAGES-1];

endmodule

[hw/rtl/rotation_matrix_to_quaternion_top.sv]
// Rotation matrix to quaternion converter, Q1.14 in and out.
// Pipeline from an accepted input beat to its output beat: front stage,
// 8 square root stages, 16 divider stages, output register.
// Throughput: one beat per cycle unless out_stall backs up the stages in turn.
// Reset: synchronous active-low rst_n clears every stage valid bit.
`include "rotation_matrix_to_quaternion_top_macros.svh"
module rotation_matrix_to_quaternion_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_r00,
  input  logic signed [15:0] in_r01,
  input  logic signed [15:0] in_r02,
  input  logic signed [15:0] in_r10,
  input  logic signed [15:0] in_r11,
  input  logic signed [15:0] in_r12,
  input  logic signed [15:0] in_r20,
  input  logic signed [15:0] in_r21,
  input  logic signed [15:0] in_r22,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_qw,
  output logic signed [15:0] out_qx,
  output logic signed [15:0] out_qy,
  output logic signed [15:0] out_qz,
  output logic               out_degenerate
);
  import rmq_pkg::*;

  logic               front_ready;
  logic               front_valid;
  logic [S_W-1:0]     front_s;
  rmq_num_t           front_num;
  logic               sqrt_ready;
  logic               sqrt_valid;
  logic [ROOT_W-1:0]  sqrt_root;
  rmq_num_t           sqrt_num;
  logic               div_ready;
  logic               div_valid;
  rmq_dstage_t        div_data;
  logic               out_en;
  logic               out_valid_r;
  logic signed [DATA_W-1:0] q_r   [LANES];
  logic signed [DATA_W-1:0] q_nxt [LANES];
  logic               degen_r;
  logic [DATA_W-1:0]  half_val;
  rmq_lane_t          lane_cur;
  logic               pivot_zero;

  rmq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (front_ready),
    .r00      (in_r00),
    .r01      (in_r01),
    .r02      (in_r02),
    .r10      (in_r10),
    .r11      (in_r11),
    .r12      (in_r12),
    .r20      (in_r20),
    .r21      (in_r21),
    .r22      (in_r22),
    .dn_valid (front_valid),
    .dn_ready (sqrt_ready),
    .dn_s     (front_s),
    .dn_num   (front_num)
  );

  rmq_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (front_valid),
    .up_ready (sqrt_ready),
    .up_s     (front_s),
    .up_num   (front_num),
    .dn_valid (sqrt_valid),
    .dn_ready (div_ready),
    .dn_root  (sqrt_root),
    .dn_num   (sqrt_num)
  );

  rmq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sqrt_valid),
    .up_ready (div_ready),
    .up_root  (sqrt_root),
    .up_num   (sqrt_num),
    .dn_valid (div_valid),
    .dn_ready (out_en),
    .dn_data  (div_data)
  );

  assign in_stall = !front_ready;
  assign out_en   = !out_valid_r || !out_stall;

  // Half-root component rounded half up, then sign and saturation per lane.
  always_comb begin
    half_val = DATA_W'(({1'b0, div_data.root} + (ROOT_W + 1)'(1)) >> 1);
    lane_cur = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_cur = rmq_lane_t'(div_data.lane[l]);
      if (div_data.meta.half_sel[l]) begin
        q_nxt[l] = div_data.meta.degen ? '0 : $signed(half_val);
      end else if (div_data.meta.degen) begin
        if (!div_data.meta.nz[l]) begin
          q_nxt[l] = '0;
        end else begin
          q_nxt[l] = div_data.meta.neg[l] ? OUT_MIN : OUT_MAX;
        end
      end else begin
        q_nxt[l] = sat_div(lane_cur.quo, div_data.meta.neg[l]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      for (int l = 0; l < LANES; l++) q_r[l] <= q_nxt[l];
      degen_r <= div_data.meta.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_qw         = q_r[0];
  assign out_qx         = q_r[1];
  assign out_qy         = q_r[2];
  assign out_qz         = q_r[3];
  assign out_degenerate = degen_r;

  // At least one output component is zero.
  assign pivot_zero = (q_r[0] == 0) || (q_r[1] == 0) || (q_r[2] == 0) || (q_r[3] == 0);

  // A stalled input means the stages are backed up to a waiting result.
  `RMQ_ASSERT(a_stall_needs_result, in_stall |-> out_valid_r, "input stalled with no result")
  // A degenerate result carries a zero pivot component.
  `RMQ_ASSERT(a_degen_pivot_zero, (out_valid_r && degen_r) |-> pivot_zero, "degenerate, no zero")
  // A divider result that cannot move is kept.
  `RMQ_ASSERT_NEXT(a_div_hold, div_valid && !out_en, div_valid, "divider beat lost")

endmodule
